FILE: hdl/gdbr_pkg.sv
// ---------------------------------------------------------------------------
// gdbr_pkg
// Shared types and constants for the remote serial protocol packet deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package gdbr_pkg;

   // Link framing characters
   localparam logic [7:0] CH_START = 8'h24;  // '$'
   localparam logic [7:0] CH_END   = 8'h23;  // '#'
   localparam logic [7:0] CH_NAK   = 8'h2D;  // '-'
   localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'

   localparam int unsigned LEN_W = 11;

   // Packet buffer size; one slot is kept for the terminator
   localparam int unsigned BUFFER_BYTES = 2048;
   localparam int unsigned CAP_RAW      = BUFFER_BYTES - 1;
   localparam logic [LEN_W-1:0] PAYLOAD_CAP =
      (CAP_RAW > 2047) ? 11'd2047 : LEN_W'(CAP_RAW);

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 11'd2047;

   // Depth of the queue between classifier and sequencer
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      KIND_BYTE   = 3'd0,
      KIND_GOOD   = 3'd1,
      KIND_BADHEX = 3'd2,
      KIND_BADSUM = 3'd3,
      KIND_OVER   = 3'd4
   } kind_type;

   // One received byte after classification
   typedef struct packed {
      logic       link_reset;
      logic       is_start;
      logic       is_end;
      logic       hex_ok;
      logic [3:0] hex_val;
      logic [7:0] data;
   } item_type;

endpackage

`default_nettype wire

FILE: hdl/gdbr_front.sv
// ---------------------------------------------------------------------------
// gdbr_front
// Input side: takes link beats and tags each byte with its framing class.
// ---------------------------------------------------------------------------
`default_nettype none

module gdbr_front (
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // [7:0] rx_byte
   input  wire logic [0:0]        req_tuser,   // [0] link_reset
   input  wire logic              queue_full,
   output logic                   push,
   output gdbr_pkg::item_type     item
);

   logic [4:0] hex_dec;

   // bit 4 set when the byte is not a hex digit (either case)
   always_comb begin
      if (req_tdata >= 8'h30 && req_tdata <= 8'h39) begin
         hex_dec = {1'b0, req_tdata[3:0]};
      end else if ((req_tdata >= 8'h41 && req_tdata <= 8'h46) ||
                   (req_tdata >= 8'h61 && req_tdata <= 8'h66)) begin
         hex_dec = {1'b0, req_tdata[3:0] + 4'd9};
      end else begin
         hex_dec = 5'h10;
      end
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      item.link_reset = req_tuser[0];
      item.is_start   = (req_tdata == gdbr_pkg::CH_START);
      item.is_end     = (req_tdata == gdbr_pkg::CH_END);
      item.hex_ok     = !hex_dec[4];
      item.hex_val    = hex_dec[3:0];
      item.data       = req_tdata;
   end

endmodule

`default_nettype wire

FILE: hdl/gdbr_queue.sv
// ---------------------------------------------------------------------------
// gdbr_queue
// Short FIFO of classified bytes between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module gdbr_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire gdbr_pkg::item_type   push_item,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      pop_valid,
   output gdbr_pkg::item_type        pop_item
);

   localparam int unsigned DEPTH = gdbr_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   gdbr_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/gdbr_back.sv
// ---------------------------------------------------------------------------
// gdbr_back
// Packet sequencer: framing state, checksum, length limit and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module gdbr_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [gdbr_pkg::LEN_W-1:0]     max_payload,
   input  wire logic                           item_valid,
   input  wire gdbr_pkg::item_type             item,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [31:0]                         rsp_tdata,  // [7:0] payload_byte,
                                                           // [18:8] packet_length,
                                                           // [26:19] reply_byte
   output logic [2:0]                          rsp_tuser   // [2:0] kind
);

   localparam int unsigned LW = gdbr_pkg::LEN_W;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_DATA = 2'd1,
      PH_CK1  = 2'd2,
      PH_CK2  = 2'd3
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [7:0]         sum_ff, sum_in;
   logic [3:0]         high_ff, high_in;
   logic [LW-1:0]      count_ff, count_in;
   logic               valid_ff, valid_in;
   gdbr_pkg::kind_type kind_ff, kind_in;
   logic [7:0]         pbyte_ff, pbyte_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [7:0]         reply_ff, reply_in;

   logic               out_free;
   logic               emit;
   logic [LW-1:0]      limit;

   assign out_free = !valid_ff || rsp_tready;
   assign pop      = item_valid && out_free;
   assign limit    = (max_payload > gdbr_pkg::PAYLOAD_CAP) ? gdbr_pkg::PAYLOAD_CAP
                                                           : max_payload;

   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      high_in  = high_ff;
      count_in = count_ff;
      emit     = 1'b0;
      kind_in  = kind_ff;
      pbyte_in = 8'd0;
      len_in   = '0;
      reply_in = 8'd0;

      if (pop) begin
         if (item.link_reset) begin
            phase_in = PH_HUNT;
            sum_in   = 8'd0;
            high_in  = 4'd0;
            count_in = '0;
         end else begin
            unique case (phase_ff)
               PH_HUNT: begin
                  if (item.is_start) begin
                     phase_in = PH_DATA;
                     sum_in   = 8'd0;
                     high_in  = 4'd0;
                     count_in = '0;
                  end
               end
               PH_DATA: begin
                  priority if (item.is_end) begin
                     phase_in = PH_CK1;
                  end else if (count_ff >= limit) begin
                     phase_in = PH_HUNT;
                     sum_in   = 8'd0;
                     high_in  = 4'd0;
                     count_in = '0;
                     emit     = 1'b1;
                     kind_in  = gdbr_pkg::KIND_OVER;
                  end else begin
                     sum_in   = sum_ff + item.data;
                     count_in = count_ff + 1'b1;
                     emit     = 1'b1;
                     kind_in  = gdbr_pkg::KIND_BYTE;
                     pbyte_in = item.data;
                  end
               end
               PH_CK1: begin
                  if (!item.hex_ok) begin
                     phase_in = PH_HUNT;
                     sum_in   = 8'd0;
                     high_in  = 4'd0;
                     count_in = '0;
                     emit     = 1'b1;
                     kind_in  = gdbr_pkg::KIND_BADHEX;
                     reply_in = gdbr_pkg::CH_NAK;
                  end else begin
                     high_in  = item.hex_val;
                     phase_in = PH_CK2;
                  end
               end
               PH_CK2: begin
                  phase_in = PH_HUNT;
                  sum_in   = 8'd0;
                  high_in  = 4'd0;
                  count_in = '0;
                  emit     = 1'b1;
                  priority if (!item.hex_ok) begin
                     kind_in  = gdbr_pkg::KIND_BADHEX;
                     reply_in = gdbr_pkg::CH_NAK;
                  end else if ({high_ff, item.hex_val} != sum_ff) begin
                     kind_in  = gdbr_pkg::KIND_BADSUM;
                     reply_in = gdbr_pkg::CH_NAK;
                  end else begin
                     kind_in  = gdbr_pkg::KIND_GOOD;
                     len_in   = count_ff;
                     reply_in = gdbr_pkg::CH_ACK;
                  end
               end
               default: begin
                  phase_in = PH_HUNT;
               end
            endcase
         end
      end

      // result register: load on a new result, drop once taken
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         sum_ff   <= 8'd0;
         high_ff  <= 4'd0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         high_ff  <= high_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         if (emit) begin
            kind_ff  <= kind_in;
            pbyte_ff <= pbyte_in;
            len_ff   <= len_in;
            reply_ff <= reply_in;
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, reply_ff, len_ff, pbyte_ff};
   assign rsp_tuser  = kind_ff;

endmodule

`default_nettype wire

FILE: hdl/gdb_rsp_packet_receiver_top.sv
// ---------------------------------------------------------------------------
// gdb_rsp_packet_receiver_top
// Remote serial protocol packet deframer with ack/nak verdicts.
// ---------------------------------------------------------------------------
// Input stream req_*: one link byte per beat in req_tdata, req_tuser[0] is
// the link-reset flag (drops any partial packet, byte ignored).
// Result stream rsp_*: at most one result beat per input beat. rsp_tuser is
// the result kind (payload byte, good, bad hex, bad checksum, overflow);
// rsp_tdata carries payload byte, packet length and the reply character.
// Bytes outside a '$'...'#xx' frame, the '$', '#' and a valid first checksum
// digit produce no result.
// Throughput is one byte per cycle while rsp_tready stays high: a two-entry
// queue sits between the classifier and the sequencer, and the sequencer
// updates its state on every byte it pops. Each input beat passes through the
// queue and then the result register before its result beat appears.
// When rsp_tready is low with a result waiting, the result register holds;
// the queue takes at most two more beats, then req_tready drops.
// csr_wr_en/csr_wr_data set the payload limit (reset 2047); write only when
// idle. Synchronous reset returns to hunting for '$' with empty queue.
// ---------------------------------------------------------------------------
`default_nettype none

module gdb_rsp_packet_receiver_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,    // [7:0] rx_byte
   input  wire logic [0:0]   req_tuser,    // [0] link_reset
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,    // [7:0] payload_byte, [18:8] packet_length,
                                           // [26:19] reply_byte
   output logic [2:0]        rsp_tuser,    // [2:0] kind
   input  wire logic         csr_wr_en,
   input  wire logic [10:0]  csr_wr_data   // max_payload
);

   logic [gdbr_pkg::LEN_W-1:0] max_payload_ff;
   logic                       push;
   logic                       full;
   logic                       pop;
   logic                       q_valid;
   gdbr_pkg::item_type         push_item;
   gdbr_pkg::item_type         q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= gdbr_pkg::MAX_PAYLOAD_RST;
      end else if (csr_wr_en) begin
         max_payload_ff <= csr_wr_data;
      end
   end

   gdbr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (full),
      .push       (push),
      .item       (push_item)
   );

   gdbr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_item  (q_item)
   );

   gdbr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .max_payload (max_payload_ff),
      .item_valid  (q_valid),
      .item        (q_item),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: hdl/gdbr_checker.sv
// ---------------------------------------------------------------------------
// gdbr_checker
// Port-level checks on the deframer's result stream.
// ---------------------------------------------------------------------------
`default_nettype none

module gdbr_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [31:0]  rsp_tdata,
   input  wire logic [2:0]   rsp_tuser
);

   logic [7:0]  pbyte;
   logic [10:0] plen;
   logic [7:0]  reply;

   assign pbyte = rsp_tdata[7:0];
   assign plen  = rsp_tdata[18:8];
   assign reply = rsp_tdata[26:19];

   // no result can come out of reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed under stall");

   a_byte_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == gdbr_pkg::KIND_BYTE |-> reply == 8'd0 && plen == 11'd0)
      else $error("payload byte result carries reply or length");

   a_good_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == gdbr_pkg::KIND_GOOD |->
         reply == gdbr_pkg::CH_ACK && pbyte == 8'd0)
      else $error("good packet without ack");

   a_nak: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == gdbr_pkg::KIND_BADHEX ||
                     rsp_tuser == gdbr_pkg::KIND_BADSUM) |->
         reply == gdbr_pkg::CH_NAK && plen == 11'd0)
      else $error("error verdict without nak");

endmodule

bind gdb_rsp_packet_receiver_top gdbr_checker u_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the packet deframer. Link bytes are sent with
// random gaps while the result side stalls at random. Every result beat is
// predicted from the byte stream and compared field by field, across
// several payload limits.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_CYCLES  = 64;
   localparam int DRAIN_CYCLES = 6;

   typedef enum logic [1:0] {PH_HUNT, PH_PAYLOAD, PH_CK_HI, PH_CK_LO} link_phase_type;

   typedef enum {PKT_GOOD, PKT_BADSUM, PKT_BADHEX_HI, PKT_BADHEX_LO, PKT_DROPPED}
      frame_flavor_type;

   typedef struct packed {
      gdbr_pkg::kind_type kind;
      logic [7:0]         payload_byte;
      logic [10:0]        packet_length;
      logic [7:0]         reply_byte;
   } verdict_type;

   typedef struct packed {
      logic       lr;
      logic [7:0] b;
   } link_beat_type;

   // Deframer state mirror plus the queue of results still owed
   class frame_scoreboard;
      link_phase_type phase;
      logic [7:0]     running_sum;
      logic [3:0]     sum_hi;
      logic [10:0]    byte_count;
      logic [10:0]    limit_reg;
      verdict_type    awaited[$];
      int             errors;
      int             seen[5];

      function new();
         limit_reg = gdbr_pkg::MAX_PAYLOAD_RST;
         errors = 0;
         foreach (seen[i]) seen[i] = 0;
         drop_frame();
      endfunction

      function void drop_frame();
         phase = PH_HUNT;
         running_sum = 8'h00;
         sum_hi = 4'h0;
         byte_count = 11'd0;
      endfunction

      function void set_limit(logic [10:0] v);
         limit_reg = v;
      endfunction

      // bit 4 set: not a hex digit
      function logic [4:0] hex_digit(logic [7:0] c);
         if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
         if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
         if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 10)};
         return 5'h10;
      endfunction

      function void note_beat(logic [7:0] b, logic lr);
         logic [4:0]  nib;
         logic [10:0] cap;
         if (lr) begin
            drop_frame();
            return;
         end
         case (phase)
            PH_HUNT: begin
               if (b == gdbr_pkg::CH_START) begin
                  drop_frame();
                  phase = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               cap = (limit_reg < gdbr_pkg::PAYLOAD_CAP) ? limit_reg : gdbr_pkg::PAYLOAD_CAP;
               if (b == gdbr_pkg::CH_END) begin
                  phase = PH_CK_HI;
               end else if (byte_count >= cap) begin
                  drop_frame();
                  awaited.push_back('{gdbr_pkg::KIND_OVER, 8'h00, 11'd0, 8'h00});
               end else begin
                  running_sum += b;
                  byte_count += 11'd1;
                  awaited.push_back('{gdbr_pkg::KIND_BYTE, b, 11'd0, 8'h00});
               end
            end
            PH_CK_HI: begin
               nib = hex_digit(b);
               if (nib[4]) begin
                  drop_frame();
                  awaited.push_back('{gdbr_pkg::KIND_BADHEX, 8'h00, 11'd0, gdbr_pkg::CH_NAK});
               end else begin
                  sum_hi = nib[3:0];
                  phase = PH_CK_LO;
               end
            end
            default: begin
               nib = hex_digit(b);
               if (nib[4])
                  awaited.push_back('{gdbr_pkg::KIND_BADHEX, 8'h00, 11'd0, gdbr_pkg::CH_NAK});
               else if ({sum_hi, nib[3:0]} != running_sum)
                  awaited.push_back('{gdbr_pkg::KIND_BADSUM, 8'h00, 11'd0, gdbr_pkg::CH_NAK});
               else
                  awaited.push_back('{gdbr_pkg::KIND_GOOD, 8'h00, byte_count,
                                      gdbr_pkg::CH_ACK});
               drop_frame();
            end
         endcase
      endfunction

      function void compare(string field, logic [31:0] exp_v, logic [31:0] act_v);
         if (act_v !== exp_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
         end
      endfunction

      function void check_result(logic [2:0] tuser, logic [31:0] tdata);
         verdict_type e;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, got kind %0d data %h",
                     $time, tuser, tdata);
            return;
         end
         e = awaited.pop_front();
         seen[e.kind]++;
         compare("kind", e.kind, tuser);
         compare("payload_byte", e.payload_byte, tdata[7:0]);
         compare("packet_length", e.packet_length, tdata[18:8]);
         compare("reply_byte", e.reply_byte, tdata[26:19]);
         compare("tdata pad", 32'd0, tdata[31:27]);
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic [0:0]  req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [10:0] csr_wr_data = 11'd0;

   frame_scoreboard sb;
   link_beat_type   beat_q[$];
   int              sent_beats = 0;
   int              stall_cycles = 0;
   int              cycles = 0;
   int              hold_req = 0;
   int              tx_calm = 0;
   int              rx_calm = 0;
   int              lim_v;
   bit              no_gaps = 1'b0;

   gdb_rsp_packet_receiver_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (!reset && req_tvalid && !req_tready) stall_cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycles, sb.pending());
         $display("[gdb_rsp_packet_receiver_top] ERROR");
         $finish;
      end
   end

   // wait per beat; now and then a run of back-to-back beats
   function automatic int draw_wait(ref int calm);
      if (calm == 0 && $urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic void push_beat(logic [7:0] b, logic lr = 1'b0);
      beat_q.push_back('{lr, b});
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] v);
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
      return c;
   endfunction

   function automatic void push_frame(int len, frame_flavor_type flavor);
      logic [7:0] sum = 8'h00;
      logic [7:0] b;
      int         start;
      int         cut;
      start = beat_q.size();
      push_beat(gdbr_pkg::CH_START);
      for (int i = 0; i < len; i++) begin
         do b = 8'($urandom_range(0, 255)); while (b == gdbr_pkg::CH_END);
         sum += b;
         push_beat(b);
      end
      push_beat(gdbr_pkg::CH_END);
      case (flavor)
         PKT_BADHEX_HI: push_beat(non_hex_byte());
         PKT_BADHEX_LO: begin
            push_beat(hex_char(sum[7:4]));
            push_beat(non_hex_byte());
         end
         default: begin
            if (flavor == PKT_BADSUM) sum ^= 8'($urandom_range(1, 255));
            push_beat(hex_char(sum[7:4]));
            push_beat(hex_char(sum[3:0]));
         end
      endcase
      // link restart somewhere after the '$', before the last digit
      if (flavor == PKT_DROPPED) begin
         cut = $urandom_range(start + 1, beat_q.size() - 1);
         while (beat_q.size() > cut) void'(beat_q.pop_back());
         push_beat(8'($urandom_range(0, 255)), 1'b1);
      end
   endfunction

   // mostly well-formed frames; lengths near a small limit hit overflow
   function automatic void push_traffic(int n_beats, int lim, int len_max);
      int stop;
      int roll;
      int len;
      stop = beat_q.size() + n_beats;
      while (beat_q.size() < stop) begin
         roll = $urandom_range(0, 99);
         if (lim <= 64 && $urandom_range(0, 6) == 0)
            len = lim + $urandom_range(0, 1);
         else
            len = $urandom_range(0, len_max);
         if (roll < 8) begin
            repeat ($urandom_range(1, 4))
               push_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
         end else if (roll < 70) begin
            push_frame(len, PKT_GOOD);
         end else if (roll < 80) begin
            push_frame(len, PKT_BADSUM);
         end else if (roll < 86) begin
            push_frame(len, PKT_BADHEX_HI);
         end else if (roll < 92) begin
            push_frame(len, PKT_BADHEX_LO);
         end else begin
            push_frame(len, PKT_DROPPED);
         end
      end
   endfunction

   task automatic send_all();
      link_beat_type bt;
      int            gap;
      while (beat_q.size() > 0) begin
         bt = beat_q.pop_front();
         gap = no_gaps ? 0 : draw_wait(tx_calm);
         @(negedge clock);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= bt.b;
         req_tuser  <= bt.lr;
         do @(posedge clock); while (!req_tready);
         sb.note_beat(bt.b, bt.lr);
         sent_beats++;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      // '#' and first digit leave no result, so give the pipe time to settle
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [10:0] v);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_limit(v);
   endtask

   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_req != 0) begin
            stall = HOLD_CYCLES;
            hold_req = 0;
         end else begin
            stall = draw_wait(rx_calm);
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tuser, rsp_tdata);
      end
   end

   initial begin : stimulus
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // hunting: stray bytes, link restart carrying a '$', lone '#'
      push_beat(8'h00);
      push_beat(gdbr_pkg::CH_START, 1'b1);
      push_beat(gdbr_pkg::CH_END);
      // 00, FF and an inner '$' as payload; sum 0x23
      push_beat(gdbr_pkg::CH_START);
      push_beat(8'h00);
      push_beat(8'hFF);
      push_beat(gdbr_pkg::CH_START);
      push_beat(gdbr_pkg::CH_END);
      push_beat("2");
      push_beat("3");
      // lower-case checksum digit
      push_beat(gdbr_pkg::CH_START);
      push_beat("a");
      push_beat("b");
      push_beat(gdbr_pkg::CH_END);
      push_beat("c");
      push_beat("3");
      // bad first digit, bad second digit, wrong sum, restart mid-payload
      push_beat(gdbr_pkg::CH_START);
      push_beat(gdbr_pkg::CH_END);
      push_beat("G");
      push_beat(gdbr_pkg::CH_START);
      push_beat(gdbr_pkg::CH_END);
      push_beat("0");
      push_beat("z");
      push_beat(gdbr_pkg::CH_START);
      push_beat("q");
      push_beat(gdbr_pkg::CH_END);
      push_beat("F");
      push_beat("F");
      push_beat(gdbr_pkg::CH_START);
      push_beat("a");
      push_beat(8'h55, 1'b1);
      send_all();

      push_traffic(270, 2047, 12);
      send_all();

      // zero limit: any payload byte overflows, empty frame still acked
      write_limit(11'd0);
      push_beat(gdbr_pkg::CH_START);
      push_beat("a");
      push_beat(gdbr_pkg::CH_START);
      push_beat(gdbr_pkg::CH_END);
      push_beat("0");
      push_beat("0");
      push_traffic(60, 0, 3);
      send_all();

      write_limit(11'd1);
      push_traffic(140, 1, 3);
      send_all();

      lim_v = $urandom_range(2, 40);
      write_limit(11'(lim_v));
      // result side holds off while bytes keep coming back to back
      hold_req = 1;
      no_gaps = 1'b1;
      repeat (3) push_frame(20, PKT_GOOD);
      send_all();
      no_gaps = 1'b0;
      push_traffic(270, lim_v, lim_v + 2);
      send_all();

      write_limit(gdbr_pkg::MAX_PAYLOAD_RST);
      push_traffic(60, 2047, 8);
      send_all();

      wait_drained();
      $display("Sent %0d link beats under payload limits 2047, 0, 1 and %0d;",
               sent_beats, lim_v);
      $display("input stalled %0d cycles. Checked %0d payload bytes, %0d acks,",
               stall_cycles, sb.seen[gdbr_pkg::KIND_BYTE], sb.seen[gdbr_pkg::KIND_GOOD]);
      $display("%0d bad-digit naks, %0d sum naks, %0d overflows.",
               sb.seen[gdbr_pkg::KIND_BADHEX], sb.seen[gdbr_pkg::KIND_BADSUM],
               sb.seen[gdbr_pkg::KIND_OVER]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[gdb_rsp_packet_receiver_top] OK");
      end else begin
         $display("[gdb_rsp_packet_receiver_top] ERROR");
      end
      $finish;
   end

endmodule
